// ----- rtl/drum_voice_mixer_defines.svh -----
// Assertion shorthands for the drum voice mixer.
// Both sample on the rising edge of clk and are off while rst is high.
`ifndef DRUM_VOICE_MIXER_DEFINES_SVH
`define DRUM_VOICE_MIXER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define DVM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define DVM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/dvm_pkg.sv -----
package dvm_pkg;

  // Field widths
  localparam int MODE_W   = 3;
  localparam int DRUM_W   = 4;
  localparam int ADDR_W   = 16;
  localparam int SAMPLE_W = 16;
  localparam int LEN_W    = 17;

  typedef logic [MODE_W-1:0]          mode_t;
  typedef logic [DRUM_W-1:0]          drum_t;
  typedef logic [ADDR_W-1:0]          addr_t;
  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [LEN_W-1:0]           len_t;

  // Item modes
  localparam mode_t MODE_TICK   = 3'd0;
  localparam mode_t MODE_TRIG   = 3'd1;
  localparam mode_t MODE_SAMPLE = 3'd2;
  localparam mode_t MODE_ENTRY  = 3'd3;
  localparam mode_t MODE_CLEAR  = 3'd4;

  // Mix clamp limits
  localparam int MIX_HIGH_LIMIT = 32766;
  localparam int MIX_HIGH       = 32767;
  localparam int MIX_LOW        = -32767;

endpackage

// ----- rtl/drum_voice_mixer.sv -----
// Drum voice mixer: sample-playback voices summed into one mono stream.
// Input channel (in_valid/in_stall) carries one item per command: tick,
// trigger drum, write sample word, write drum entry, clear voices.
// Output channel (out_valid/out_stall) returns exactly one item per input
// item, in order: mix_sample and sample_valid on a tick, status on a trigger.
// Items are processed one at a time; in_stall is high while one is at work.
// Steps from input accept to out_valid: a tick reads one voice record per
// cycle from the voice RAM, then does the sample RAM read and accumulate;
// a trigger reads the drum table, or goes straight on when no voice is free;
// a sample or entry write runs the address reduction steps (1 at 65536
// words); clear or unknown mode goes straight to the result. The next item
// is accepted once the block is back in idle.
// The result sits in an output register, so the next item is accepted while
// it waits; if out_stall is still high when the next result is ready, the
// block holds that result and stalls its input until the register frees.
// Reset frees all voices and marks every drum not loaded; no clearing pass
// is needed and the first item can be accepted right after reset.
`include "drum_voice_mixer_defines.svh"

module drum_voice_mixer #(
  parameter int VOICES    = 8,
  parameter int DRUMS     = 16,
  parameter int RAM_WORDS = 65536
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  dvm_pkg::mode_t   mode,
  input  dvm_pkg::drum_t   drum,
  input  dvm_pkg::addr_t   address,
  input  dvm_pkg::sample_t sample_value,
  input  dvm_pkg::len_t    length,
  input  logic             loaded,
  output logic             out_valid,
  input  logic             out_stall,
  output dvm_pkg::sample_t mix_sample,
  output logic             sample_valid,
  output logic             status
);

  import dvm_pkg::*;

  localparam int AW      = (RAM_WORDS > 1) ? $clog2(RAM_WORDS) : 1;
  localparam int VW      = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int VCW     = $clog2(VOICES + 1);
  localparam int DW      = (DRUMS > 1) ? $clog2(DRUMS) : 1;
  localparam int SUM_W   = SAMPLE_W + VW;
  localparam int REC_W   = AW + LEN_W;
  localparam int QMAX    = 65535 / RAM_WORDS;
  localparam int RED_STEPS = (QMAX > 0) ? $clog2(QMAX + 1) : 1;
  localparam int STEP_W  = (RED_STEPS > 1) ? $clog2(RED_STEPS) : 1;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_REDUCE = 3'd1;
  localparam logic [2:0] ST_TRIG   = 3'd2;
  localparam logic [2:0] ST_TICK   = 3'd3;
  localparam logic [2:0] ST_FINISH = 3'd4;

  logic [2:0]        state;
  logic [VOICES-1:0] busy;
  logic [DRUMS-1:0]  drum_ready;

  // Latched item
  mode_t             cmd_mode;
  drum_t             cmd_drum;
  sample_t           cmd_value;
  len_t              cmd_len;
  logic              cmd_loaded;
  logic [VW-1:0]     cmd_voice;
  addr_t             red_addr;
  logic [STEP_W-1:0] red_step;

  // Tick pipeline
  logic [VCW-1:0]          issue_cnt;
  logic                    s1_valid;
  logic                    s1_busy;
  logic [VW-1:0]           s1_voice;
  logic                    s2_valid;
  logic                    s2_busy;
  logic signed [SUM_W-1:0] sum_acc;

  // Pending result and output register
  sample_t res_mix;
  logic    res_valid;
  logic    res_status;

  // Memory ports
  logic             s_we;
  logic [AW-1:0]    s_waddr;
  logic [AW-1:0]    s_raddr;
  logic [SAMPLE_W-1:0] s_wdata;
  logic [SAMPLE_W-1:0] s_rdata;
  logic             v_we;
  logic [VW-1:0]    v_waddr;
  logic [VW-1:0]    v_raddr;
  logic [REC_W-1:0] v_wdata;
  logic [REC_W-1:0] v_rdata;
  logic             d_we;
  logic [DW-1:0]    d_waddr;
  logic [DW-1:0]    d_raddr;
  logic [REC_W-1:0] d_wdata;
  logic [REC_W-1:0] d_rdata;

  // Combinational helpers
  logic                accept;
  logic                out_load;
  logic                free_found;
  logic [VW-1:0]       free_idx;
  logic [31:0]         red_limit;
  logic                red_take;
  addr_t               red_addr_next;
  logic                red_last;
  logic                drum_ok;
  logic [AW-1:0]       v_addr;
  logic [AW-1:0]       v_addr_inc;
  len_t                v_rem;
  len_t                v_rem_dec;
  logic                issue;
  logic                tick_end;
  sample_t             mix_clamped;

  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_load = (state == ST_FINISH) && (!out_valid || !out_stall);

  // Pick the lowest-numbered free voice
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = VOICES - 1; i >= 0; i--) begin
      if (!busy[i]) begin
        free_found = 1'b1;
        free_idx   = VW'(i);
      end
    end
  end

  // Reduce an address modulo the RAM size, one restoring step per cycle
  assign red_limit     = 32'(RAM_WORDS) << red_step;
  assign red_take      = ({16'b0, red_addr} >= red_limit);
  assign red_addr_next = red_take ? (red_addr - ADDR_W'(red_limit)) : red_addr;
  assign red_last      = (red_step == '0);
  assign drum_ok       = (32'(cmd_drum) < DRUMS);

  // Advance the voice record read back from the voice RAM
  assign v_addr     = v_rdata[REC_W-1 -: AW];
  assign v_rem      = v_rdata[LEN_W-1:0];
  assign v_addr_inc = (v_addr == AW'(RAM_WORDS - 1)) ? '0 : (v_addr + 1'b1);
  assign v_rem_dec  = v_rem - 1'b1;

  assign issue    = (state == ST_TICK) && (issue_cnt != VCW'(VOICES));
  assign tick_end = (state == ST_TICK) && !issue && !s1_valid && !s2_valid;

  // Clamp the finished mix
  always_comb begin
    mix_clamped = SAMPLE_W'(sum_acc);
    if (sum_acc > SUM_W'(MIX_HIGH_LIMIT)) begin
      mix_clamped = SAMPLE_W'(MIX_HIGH);
    end else if (sum_acc < SUM_W'(MIX_LOW)) begin
      mix_clamped = SAMPLE_W'(MIX_LOW);
    end
  end

  // Sample RAM: write on a sample item, read during a tick
  assign s_we    = (state == ST_REDUCE) && red_last && (cmd_mode == MODE_SAMPLE);
  assign s_waddr = AW'(red_addr_next);
  assign s_wdata = cmd_value;
  assign s_raddr = v_addr;

  // Drum table: write on an entry item, read at trigger accept
  assign d_we    = (state == ST_REDUCE) && red_last && (cmd_mode == MODE_ENTRY) && drum_ok;
  assign d_waddr = DW'(cmd_drum);
  assign d_wdata = {AW'(red_addr_next), cmd_len};
  assign d_raddr = DW'(drum);

  // Voice RAM: start a voice on trigger, write back advanced voices on tick
  assign v_raddr = issue_cnt[VW-1:0];
  always_comb begin
    v_we    = 1'b0;
    v_waddr = s1_voice;
    v_wdata = {v_addr_inc, v_rem_dec};
    if (state == ST_TRIG) begin
      v_we    = 1'b1;
      v_waddr = cmd_voice;
      v_wdata = d_rdata;
    end else if (s1_valid && s1_busy) begin
      v_we = 1'b1;
    end
  end

  dvm_ram #(.WIDTH(SAMPLE_W), .DEPTH(RAM_WORDS)) u_sample_ram (
    .clk   (clk),
    .we    (s_we),
    .waddr (s_waddr),
    .wdata (s_wdata),
    .raddr (s_raddr),
    .rdata (s_rdata)
  );

  dvm_ram #(.WIDTH(REC_W), .DEPTH(VOICES)) u_voice_ram (
    .clk   (clk),
    .we    (v_we),
    .waddr (v_waddr),
    .wdata (v_wdata),
    .raddr (v_raddr),
    .rdata (v_rdata)
  );

  dvm_ram #(.WIDTH(REC_W), .DEPTH(DRUMS)) u_drum_ram (
    .clk   (clk),
    .we    (d_we),
    .waddr (d_waddr),
    .wdata (d_wdata),
    .raddr (d_raddr),
    .rdata (d_rdata)
  );

  // Control sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      busy       <= '0;
      drum_ready <= '0;
      out_valid  <= 1'b0;
      s1_valid   <= 1'b0;
      s2_valid   <= 1'b0;
    end else begin
      // Load the output register, or drop its item once taken
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      // Advance the tick pipeline
      s1_valid <= issue;
      s1_voice <= issue_cnt[VW-1:0];
      s1_busy  <= busy[issue_cnt[VW-1:0]];
      s2_valid <= s1_valid;
      s2_busy  <= s1_valid && s1_busy;
      if (s1_valid && s1_busy) begin
        busy[s1_voice] <= (v_rem_dec != '0);
      end
      if (s2_valid && s2_busy) begin
        sum_acc <= sum_acc + SUM_W'($signed(s_rdata));
      end

      case (state)
        ST_IDLE: begin
          if (accept) begin
            cmd_mode   <= mode;
            cmd_drum   <= drum;
            cmd_value  <= sample_value;
            cmd_len    <= length;
            cmd_loaded <= loaded;
            res_mix    <= '0;
            res_valid  <= 1'b0;
            res_status <= (mode == MODE_TRIG) && !free_found;
            case (mode)
              MODE_TICK: begin
                issue_cnt <= '0;
                sum_acc   <= '0;
                state     <= ST_TICK;
              end
              MODE_TRIG: begin
                if (free_found) begin
                  cmd_voice <= free_idx;
                  state     <= ST_TRIG;
                end else begin
                  state <= ST_FINISH;
                end
              end
              MODE_SAMPLE, MODE_ENTRY: begin
                red_addr <= address;
                red_step <= STEP_W'(RED_STEPS - 1);
                state    <= ST_REDUCE;
              end
              MODE_CLEAR: begin
                busy  <= '0;
                state <= ST_FINISH;
              end
              default: begin
                state <= ST_FINISH;
              end
            endcase
          end
        end
        ST_REDUCE: begin
          red_addr <= red_addr_next;
          red_step <= red_step - 1'b1;
          if (red_last) begin
            if ((cmd_mode == MODE_ENTRY) && drum_ok) begin
              drum_ready[DW'(cmd_drum)] <= cmd_loaded;
            end
            state <= ST_FINISH;
          end
        end
        ST_TRIG: begin
          // Voice stays idle for an unloaded drum or a zero length
          busy[cmd_voice] <= drum_ok && drum_ready[DW'(cmd_drum)] &&
                             (d_rdata[LEN_W-1:0] != '0);
          state <= ST_FINISH;
        end
        ST_TICK: begin
          if (issue) begin
            issue_cnt <= issue_cnt + 1'b1;
          end
          if (tick_end) begin
            res_mix   <= mix_clamped;
            res_valid <= 1'b1;
            state     <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          // Hold the result until the output register is free
          if (out_load) begin
            mix_sample   <= res_mix;
            sample_valid <= res_valid;
            status       <= res_status;
            state        <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `DVM_ASSERT_NEXT(a_accept_stalls, in_valid && !in_stall, in_stall, "input not stalled after accept")
  `DVM_ASSERT_NOW(a_idle_pipe_empty, state == ST_IDLE, !s1_valid && !s2_valid, "tick pipeline busy in idle")
  `DVM_ASSERT_NOW(a_mix_clamped, out_valid && sample_valid, mix_sample != 16'h8000, "mix outside clamp range")
  `DVM_ASSERT_NOW(a_one_kind, out_valid, !(sample_valid && status), "tick result carries busy status")
  `DVM_ASSERT_NOW(a_non_tick_zero, out_valid && !sample_valid, mix_sample == '0, "non-tick result has nonzero mix")

endmodule

// ----- rtl/dvm_ram.sv -----
module dvm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- bench/tb.sv -----
module tb;
  import dvm_pkg::*;

  localparam int VOICES = 8;
  localparam int DRUMS  = 16;
  localparam int PHASE_ITEMS = 500;
  localparam int SETTLE_CYCLES = 40;
  localparam int REPORT_LIMIT = 10;
  localparam mode_t MODE_LAST = '1;

  typedef struct packed {
    mode_t   mode;
    drum_t   drum;
    addr_t   address;
    sample_t value;
    len_t    length;
    logic    loaded;
  } drum_cmd_t;

  typedef struct packed {
    sample_t mix;
    logic    valid;
    logic    status;
  } mix_result_t;

  typedef struct packed {
    drum_cmd_t   cmd;
    mix_result_t want;
  } cmd_entry_t;

  // Block ports
  logic    clk;
  logic    rst = 1'b1;
  logic    in_valid = 1'b0;
  logic    in_stall;
  mode_t   mode = '0;
  drum_t   drum = '0;
  addr_t   address = '0;
  sample_t sample_value = '0;
  len_t    length = '0;
  logic    loaded = 1'b0;
  logic    out_valid;
  logic    out_stall = 1'b0;
  sample_t mix_sample;
  logic    sample_valid;
  logic    status;

  // Predicted mixer state
  len_t    voice_left [VOICES] = '{default: '0};
  addr_t   voice_addr [VOICES] = '{default: '0};
  addr_t   drum_base [DRUMS] = '{default: '0};
  len_t    drum_len [DRUMS] = '{default: '0};
  logic    drum_on [DRUMS] = '{default: 1'b0};
  sample_t wave_ram [addr_t];

  cmd_entry_t  drum_cmds_pending [$];
  mix_result_t mix_results_due [$];
  cmd_entry_t  drive_next;
  mix_result_t drive_want;
  mix_result_t seen_want;

  int send_gap = 0;
  int recv_gap = 0;
  int fail_count = 0;
  int cmds_queued = 0;

  drum_voice_mixer #(
    .VOICES(VOICES),
    .DRUMS(DRUMS)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .mode(mode),
    .drum(drum),
    .address(address),
    .sample_value(sample_value),
    .length(length),
    .loaded(loaded),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .mix_sample(mix_sample),
    .sample_valid(sample_valid),
    .status(status)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Apply one item to the predicted state and return its result
  function automatic mix_result_t next_mix_result(drum_cmd_t c);
    mix_result_t r;
    int sum;
    int v;
    r = '0;
    case (c.mode)
      MODE_TICK: begin
        sum = 0;
        for (v = 0; v < VOICES; v++) begin
          if (voice_left[v] != '0) begin
            sum += wave_ram[voice_addr[v]];
            voice_addr[v] = voice_addr[v] + 1'b1;
            voice_left[v] = voice_left[v] - 1'b1;
          end
        end
        if (sum > MIX_HIGH_LIMIT) sum = MIX_HIGH;
        if (sum < MIX_LOW) sum = MIX_LOW;
        r.mix = sample_t'(sum);
        r.valid = 1'b1;
      end
      MODE_TRIG: begin
        v = 0;
        while (v < VOICES && voice_left[v] != '0) v++;
        if (v == VOICES) begin
          r.status = 1'b1;
        end else begin
          // an unloaded drum still claims the voice but leaves it idle
          voice_addr[v] = drum_base[c.drum];
          voice_left[v] = drum_on[c.drum] ? drum_len[c.drum] : '0;
        end
      end
      MODE_SAMPLE: begin
        wave_ram[c.address] = c.value;
      end
      MODE_ENTRY: begin
        drum_base[c.drum] = c.address;
        drum_len[c.drum] = c.length;
        drum_on[c.drum] = c.loaded;
      end
      MODE_CLEAR: begin
        for (v = 0; v < VOICES; v++) voice_left[v] = '0;
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  function automatic sample_t pick_sample();
    case ($urandom_range(7))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return '0;
      3: return '1;
      default: return sample_t'($urandom);
    endcase
  endfunction

  // Favor a low window and the top of RAM so playback wraps often
  function automatic addr_t pick_addr();
    case ($urandom_range(7))
      0: return addr_t'($urandom);
      1, 2: return addr_t'(16'hffc0 + $urandom_range(63));
      default: return addr_t'($urandom_range(511));
    endcase
  endfunction

  function automatic drum_cmd_t cmd_of(mode_t m, drum_t d, addr_t a, sample_t s, len_t l,
                                       logic ld);
    drum_cmd_t c;
    c.mode = m;
    c.drum = d;
    c.address = a;
    c.value = s;
    c.length = l;
    c.loaded = ld;
    return c;
  endfunction

  function automatic drum_cmd_t random_cmd();
    drum_cmd_t c;
    int pick;
    c = cmd_of(MODE_TICK, drum_t'($urandom), addr_t'($urandom), sample_t'($urandom),
               len_t'($urandom_range(65536)), 1'($urandom));
    pick = $urandom_range(99);
    if (pick < 45) begin
      c.mode = MODE_TICK;
    end else if (pick < 65) begin
      c.mode = MODE_TRIG;
    end else if (pick < 77) begin
      c.mode = MODE_ENTRY;
      c.address = pick_addr();
      c.loaded = ($urandom_range(99) < 85);
      // mostly short hits, some empty, some up to the full length range
      case ($urandom_range(9))
        0: c.length = '0;
        1: begin
        end
        default: c.length = len_t'($urandom_range(1, 48));
      endcase
    end else if (pick < 92) begin
      c.mode = MODE_SAMPLE;
      c.address = pick_addr();
      c.value = pick_sample();
    end else if (pick < 97) begin
      c.mode = MODE_CLEAR;
    end else begin
      c.mode = mode_t'($urandom_range(MODE_CLEAR + 1, MODE_LAST));
    end
    return c;
  endfunction

  // Queue an item; ahead of a tick, write any unwritten sample word a voice is about to read
  task automatic push_cmd(drum_cmd_t c);
    cmd_entry_t e;
    int v;
    if (c.mode == MODE_TICK) begin
      for (v = 0; v < VOICES; v++) begin
        if (voice_left[v] != '0 && !wave_ram.exists(voice_addr[v]))
          push_cmd(cmd_of(MODE_SAMPLE, drum_t'($urandom), voice_addr[v], pick_sample(),
                          len_t'($urandom_range(65536)), 1'($urandom)));
      end
    end
    e.cmd = c;
    e.want = next_mix_result(c);
    drum_cmds_pending.push_back(e);
    cmds_queued++;
  endtask

  task automatic note_failure(string msg);
    if (fail_count < REPORT_LIMIT) $display("%s", msg);
    fail_count++;
  endtask

  // Drive items; hold the payload while stalled
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) mix_results_due.push_back(drive_want);
      if (!in_valid || !in_stall) begin
        if (drum_cmds_pending.size() != 0 && $urandom_range(99) >= send_gap) begin
          drive_next = drum_cmds_pending.pop_front();
          drive_want = drive_next.want;
          in_valid <= 1'b1;
          mode <= drive_next.cmd.mode;
          drum <= drive_next.cmd.drum;
          address <= drive_next.cmd.address;
          sample_value <= drive_next.cmd.value;
          length <= drive_next.cmd.length;
          loaded <= drive_next.cmd.loaded;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Check each result against the oldest expectation; stall at random
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (mix_results_due.size() == 0) begin
          note_failure($sformatf("unexpected item: mix %0d valid %0b status %0b",
                                 mix_sample, sample_valid, status));
        end else begin
          seen_want = mix_results_due.pop_front();
          if (mix_sample !== seen_want.mix || sample_valid !== seen_want.valid ||
              status !== seen_want.status)
            note_failure($sformatf(
              "mismatch: mix %0d/%0d valid %0b/%0b status %0b/%0b (expected/actual)",
              seen_want.mix, mix_sample, seen_want.valid, sample_valid,
              seen_want.status, status));
        end
      end
      out_stall <= ($urandom_range(99) < recv_gap);
    end
  end

  initial begin
    int phase;
    int target;
    int n;
    send_gap = 18;
    recv_gap = 55;

    // Drum table extremes: top address, zero length, unloaded, full length
    push_cmd(cmd_of(MODE_ENTRY, 4'd15, 16'hffff, '0, 17'd3, 1'b1));
    push_cmd(cmd_of(MODE_SAMPLE, '0, 16'hffff, 16'sh7fff, '0, 1'b0));
    push_cmd(cmd_of(MODE_SAMPLE, '0, 16'h0000, 16'sh8000, '0, 1'b0));
    push_cmd(cmd_of(MODE_SAMPLE, '0, 16'h0002, -16'sd1, '0, 1'b0));
    push_cmd(cmd_of(MODE_SAMPLE, '0, 16'h0003, '0, '0, 1'b0));
    push_cmd(cmd_of(MODE_ENTRY, 4'd0, 16'h0000, '0, '0, 1'b1));
    push_cmd(cmd_of(MODE_ENTRY, 4'd1, 16'h0002, '0, 17'd65536, 1'b0));
    push_cmd(cmd_of(MODE_ENTRY, 4'd2, 16'h0002, '0, 17'd65536, 1'b1));
    push_cmd(cmd_of(MODE_TRIG, 4'd0, '0, '0, '0, 1'b0));
    push_cmd(cmd_of(MODE_TRIG, 4'd1, '0, '0, '0, 1'b0));
    push_cmd(cmd_of(MODE_TRIG, 4'd15, '0, '0, '0, 1'b0));
    push_cmd(cmd_of(MODE_TRIG, 4'd2, '0, '0, '0, 1'b0));
    // Mix just under the clamp, then a lone negative full scale, then wrap past zero
    for (n = 0; n < 3; n++) push_cmd(cmd_of(MODE_TICK, '0, '0, '0, '0, 1'b0));
    // Fill every voice, then one trigger too many
    for (n = 0; n < VOICES; n++) push_cmd(cmd_of(MODE_TRIG, 4'd2, '0, '0, '0, 1'b0));
    push_cmd(cmd_of(MODE_TICK, '0, '0, '0, '0, 1'b0));
    push_cmd(cmd_of(MODE_CLEAR, '0, '0, '0, '0, 1'b0));
    push_cmd(cmd_of(MODE_TICK, '0, '0, '0, '0, 1'b0));
    push_cmd(cmd_of(MODE_LAST, drum_t'($urandom), addr_t'($urandom), sample_t'($urandom),
                    17'd65536, 1'b1));

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    for (phase = 0; phase < 3; phase++) begin
      send_gap = (phase == 0) ? 18 : (phase == 1) ? 55 : 0;
      recv_gap = (phase == 0) ? 55 : (phase == 1) ? 18 : 0;
      target = cmds_queued + PHASE_ITEMS;
      while (cmds_queued < target) push_cmd(random_cmd());
      // Hold off new items until every result is back
      do @(negedge clk);
      while (drum_cmds_pending.size() != 0 || in_valid || mix_results_due.size() != 0);
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("drum_voice_mixer regression: pass");
    end else begin
      $display("drum_voice_mixer regression: fail");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #5000000;
    $display("drum_voice_mixer regression: fail");
    $finish;
  end

endmodule
